// ----- rtl/iee_pkg.sv -----
`timescale 1ns / 1ps
package iee_pkg;
    localparam int StackDepth = 32;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = PtrW + 1;

    typedef enum logic [3:0] {
        OP_END   = 4'd0,
        OP_OPEN  = 4'd1,
        OP_CLOSE = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_DIV   = 4'd6,
        OP_MOD   = 4'd7,
        OP_XOR   = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_READ_OP, S_DECIDE, S_POP2, S_POP1, S_ALU, S_EXEC, S_DIV, S_PUSH,
        S_DONE, S_OUT
    } t_state;

    typedef struct packed {
        logic       load_tok;
        logic       push_val;
        logic       push_opr;
        logic       pop_opr;
        logic       rd_opr;
        logic       rd_val;
        logic       pop_val_r;
        logic       pop_val_l;
        logic       alu_go;
        logic       div_go;
        logic       push_res;
        logic       flag_malf;
        logic       flag_ovf;
        logic       rd_bottom;
        logic       set_done;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       tok_kind;
        logic [3:0] tok_op;
        logic [3:0] top_op;
        logic       opr_empty;
        logic       opr_full;
        logic       val_lt2;
        logic       div_busy;
        logic       out_busy;
    } t_sts;

    function automatic logic [3:0] prio_in(input logic [3:0] op);
        case (op)
            OP_END:                  prio_in = 4'd0;
            OP_OPEN:                 prio_in = 4'd1;
            OP_CLOSE:                prio_in = 4'd8;
            OP_ADD, OP_SUB:          prio_in = 4'd3;
            OP_MUL, OP_DIV, OP_MOD:  prio_in = 4'd5;
            OP_XOR:                  prio_in = 4'd7;
            default:                 prio_in = 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] prio_new(input logic [3:0] op);
        case (op)
            OP_END:                  prio_new = 4'd0;
            OP_OPEN:                 prio_new = 4'd8;
            OP_CLOSE:                prio_new = 4'd1;
            OP_ADD, OP_SUB:          prio_new = 4'd2;
            OP_MUL, OP_DIV, OP_MOD:  prio_new = 4'd4;
            OP_XOR:                  prio_new = 4'd6;
            default:                 prio_new = 4'd0;
        endcase
    endfunction
endpackage

// ----- rtl/infix_expression_evaluator.sv -----
`timescale 1ns / 1ps
// channel | handshake          | fields
// in      | i_valid o_stall    | i_token_kind i_operand_value i_op_code (one request)
// out     | o_valid i_stall    | o_done_res o_value o_status (one result per request)
// Each operator token may first reduce stacked operators; a divide/modulo reduction waits on the
// divider, and a malformed stacked operator is popped and dropped; the divider sets the worst case.
// Reset clears stack counts, error latch and output valid.
// A stalled result holds; the next request is taken, its result waits until it can be placed.
module infix_expression_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_token_kind,
    input  logic signed [31:0] i_operand_value,
    input  logic [3:0]         i_op_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_done_res,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);
    import iee_pkg::*;
    t_cmd cmd;
    t_sts sts;
    iee_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_sts(sts), .o_cmd(cmd));
    iee_datapath u_dp (.i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_token_kind,
        .i_operand_value, .i_op_code, .i_stall, .o_valid, .o_done_res, .o_value,
        .o_status);
endmodule

// ----- rtl/iee_div.sv -----
`timescale 1ns / 1ps
module iee_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, r_d, r_r;
    logic [5:0]  r_cnt;
    logic        r_busy, r_nq, r_nr;
    logic [32:0] w_sh, w_sub;

    assign w_sh  = {r_r, r_q[31]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_q    <= i_num[31] ? -i_num : i_num;
            r_d    <= i_den[31] ? -i_den : i_den;
            r_r    <= '0;
            r_nq   <= i_num[31] ^ i_den[31];
            r_nr   <= i_num[31];
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                r_r <= w_sub[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= w_sh[31:0];
                r_q <= {r_q[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_nq ? -r_q : r_q;
    assign o_rem  = r_nr ? -r_r : r_r;
endmodule

// ----- rtl/iee_datapath.sv -----
`timescale 1ns / 1ps
module iee_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iee_pkg::t_cmd       i_cmd,
    output iee_pkg::t_sts       o_sts,
    input  logic                i_token_kind,
    input  logic signed [31:0]  i_operand_value,
    input  logic [3:0]          i_op_code,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_done_res,
    output logic signed [31:0]  o_value,
    output logic [1:0]          o_status
);
    import iee_pkg::*;

    logic [31:0]     r_vmem [StackDepth];
    logic [3:0]      r_omem [StackDepth];
    logic [CntW-1:0] r_vcnt, r_ocnt;
    logic [31:0]     r_tval, r_vrd, r_right, r_left, r_res;
    logic            r_tkind, r_done, r_ovalid, r_odone;
    logic [3:0]      r_top, r_tok;
    logic [1:0]      r_err, r_ostat;
    logic [31:0]     r_oval;
    logic            div_busy;
    logic [31:0]     quo, rem;
    logic [1:0]      n_err;
    logic [31:0]     n_push;
    logic            n_vpush, n_fault;

    iee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_left),
        .i_den   (r_right),
        .o_busy  (div_busy),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    always_comb begin
        n_push = r_res;
        if (i_cmd.push_val) n_push = r_tval;
        else if (r_top == OP_DIV) n_push = (r_right == '0) ? '0 : quo;
        else if (r_top == OP_MOD) n_push = (r_right == '0) ? '0 : rem;
        n_vpush = (i_cmd.push_val || i_cmd.push_res) && r_vcnt < CntW'(StackDepth);
        n_fault = ((i_cmd.push_val || i_cmd.push_res) && !n_vpush) || i_cmd.flag_ovf;
        n_err   = r_err;
        if (r_err == ST_OK) begin
            if (i_cmd.flag_malf || (i_cmd.set_done && r_vcnt != CntW'(1)))
                n_err = ST_MALFORMED;
            else if (n_fault) n_err = ST_OVERFLOW;
            else if (i_cmd.div_go && r_right == '0) n_err = ST_DIVZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tok) begin
            r_tkind <= i_token_kind;
            r_tval  <= i_operand_value;
            r_tok   <= i_op_code;
        end
        if (n_vpush) r_vmem[r_vcnt[PtrW-1:0]] <= n_push;
        if (i_cmd.push_opr && r_ocnt < CntW'(StackDepth))
            r_omem[r_ocnt[PtrW-1:0]] <= r_tok;
        if (i_cmd.rd_opr) r_top <= r_omem[r_ocnt[PtrW-1:0] - PtrW'(1)];
        if (i_cmd.rd_val) r_vrd <= r_vmem[r_vcnt[PtrW-1:0] - PtrW'(1)];
        if (i_cmd.rd_bottom) r_vrd <= r_vmem[0];
        if (i_cmd.pop_val_r) r_right <= r_vrd;
        if (i_cmd.pop_val_l) r_left <= r_vrd;
        if (i_cmd.alu_go) begin
            case (r_top)
                OP_ADD:  r_res <= r_left + r_right;
                OP_SUB:  r_res <= r_left - r_right;
                OP_MUL:  r_res <= r_left * r_right;
                OP_XOR:  r_res <= r_left ^ r_right;
                default: r_res <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_odone <= r_done;
            r_ostat <= n_err;
            r_oval  <= (r_done && n_err == ST_OK) ? r_vrd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt   <= '0;
            r_ocnt   <= '0;
            r_err    <= ST_OK;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.out_load && r_done) begin
                r_vcnt <= '0;
                r_ocnt <= '0;
                r_err  <= ST_OK;
                r_done <= 1'b0;
            end else begin
                r_err <= n_err;
                if (n_vpush) r_vcnt <= r_vcnt + 1'b1;
                else if (i_cmd.pop_val_r || i_cmd.pop_val_l) r_vcnt <= r_vcnt - 1'b1;
                if (i_cmd.push_opr && r_ocnt < CntW'(StackDepth)) r_ocnt <= r_ocnt + 1'b1;
                else if (i_cmd.pop_opr) r_ocnt <= r_ocnt - 1'b1;
                if (i_cmd.set_done) r_done <= 1'b1;
            end
            if (i_cmd.out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.tok_kind  = r_tkind;
        o_sts.tok_op    = r_tok;
        o_sts.top_op    = r_top;
        o_sts.opr_empty = r_ocnt == '0;
        o_sts.opr_full  = r_ocnt >= CntW'(StackDepth);
        o_sts.val_lt2   = r_vcnt < CntW'(2);
        o_sts.div_busy  = div_busy;
        o_sts.out_busy  = r_ovalid && i_stall;
    end

    assign o_valid    = r_ovalid;
    assign o_done_res = r_odone;
    assign o_value    = r_oval;
    assign o_status   = r_ostat;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CntW'(StackDepth))
        else $error("operand count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= CntW'(StackDepth))
        else $error("operator count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK |=> r_err == $past(r_err) || $past(i_cmd.out_load))
        else $error("error latch changed");
endmodule

// ----- rtl/iee_ctrl.sv -----
`timescale 1ns / 1ps
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  iee_pkg::t_sts i_sts,
    output iee_pkg::t_cmd o_cmd
);
    import iee_pkg::*;

    t_state r_state, n_state;
    logic [3:0] a, b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        a = i_sts.opr_empty ? prio_in(OP_END) : prio_in(i_sts.top_op);
        b = prio_new(i_sts.tok_op);
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_tok = 1'b1;
                    n_state = S_READ_OP;
                end
            end
            S_READ_OP: begin
                if (!i_sts.tok_kind) begin
                    o_cmd.push_val = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.tok_op > OP_XOR) begin
                    o_cmd.flag_malf = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_opr = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.opr_empty && i_sts.tok_op == OP_END) begin
                    o_cmd.set_done = 1'b1;
                    o_cmd.rd_bottom = 1'b1;
                    n_state = S_DONE;
                end else if (a < b) begin
                    if (i_sts.tok_op == OP_CLOSE) o_cmd.flag_malf = 1'b1;
                    else if (i_sts.opr_full) o_cmd.flag_ovf = 1'b1;
                    else o_cmd.push_opr = 1'b1;
                    n_state = S_OUT;
                end else if (a == b) begin
                    o_cmd.pop_opr = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.pop_opr = 1'b1;
                    if (i_sts.top_op == OP_OPEN || i_sts.val_lt2) begin
                        o_cmd.flag_malf = 1'b1;
                        n_state = S_READ_OP;
                    end else begin
                        o_cmd.rd_val = 1'b1;
                        n_state = S_POP2;
                    end
                end
            end
            S_POP2: begin
                o_cmd.pop_val_r = 1'b1;
                n_state = S_POP1;
            end
            S_POP1: begin
                o_cmd.rd_val = 1'b1;
                n_state = S_ALU;
            end
            S_ALU: begin
                o_cmd.pop_val_l = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.top_op == OP_DIV || i_sts.top_op == OP_MOD) begin
                    o_cmd.div_go = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.alu_go = 1'b1;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push_res = 1'b1;
                n_state = S_READ_OP;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.push_res = 1'b1;
                    n_state = S_READ_OP;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
